[sv/mme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg
// Shared widths, register indexes and the controller-to-datapath command and
// status types of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    // Default build values
    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int ELEM_W     = 32;
    localparam int DIM_CFG_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 3;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_PAD_W  = 2;
    localparam int OUT_TDATA_W = ELEM_W + 2 * ROW_W + OUT_PAD_W;

    // Dimension register reset value
    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // Saturation limits
    localparam logic [ELEM_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [ELEM_W-1:0] Q_MIN = 32'h8000_0000;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;      // store element into A
        logic             wr_b;      // store element into B
        logic             issue;     // read one A/B pair for a MAC
        logic             first;     // first term of a dot product
        logic             last;      // last term of a dot product
        logic             load_out;  // move finished sum into output register
        logic [ROW_W-1:0] out_row;
        logic [ROW_W-1:0] out_col;
        logic             out_last;
    } mme_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sum_done;  // accumulator holds a complete dot product
    } mme_status_t;

endpackage

[sv/mme_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/mme_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller: holds the dimension registers and the load position, steers
// elements into the A/B stores and sequences the row/column/inner loops.
// ----------------------------------------------------------------------------
module mme_ctrl #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF,
    localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mme_pkg::DIM_CFG_W-1:0]   cfg_wdata,
    // handshakes
    input  logic                            s_tvalid,
    output logic                            s_tready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // datapath control
    output mme_pkg::mme_cmd_t               cmd,
    input  mme_pkg::mme_status_t            status,
    output logic [AW-1:0]                   waddr,
    output logic [AW-1:0]                   raddr_a,
    output logic [AW-1:0]                   raddr_b
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int LC_W  = $clog2(2 * MAX_DIM * MAX_DIM + 1);
    localparam int MUL_W = IDX_W + DIM_W;
    localparam int NA_W  = 2 * DIM_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_EMIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [LC_W-1:0]               load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]              r_reg, r_next;
    logic [IDX_W-1:0]              c_reg, c_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    logic                          out_valid_reg, out_valid_next;
    logic [mme_pkg::DIM_CFG_W-1:0] rows_reg, inner_reg, cols_reg;

    logic [DIM_W-1:0] nr, nk, nc;
    logic [NA_W-1:0]  na_full, nb_full;
    logic [LC_W-1:0]  na, nb, total, pos_inc, offs_b;
    logic             in_a, in_b, s_xfer;
    logic             r_end, c_end, k_end;
    logic [MUL_W-1:0] a_base, b_base;

    // Out-of-range dimension: zero acts as one, above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mme_pkg::DIM_CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > mme_pkg::DIM_CFG_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v[DIM_W-1:0];
        end
        return res;
    endfunction

    // Effective sizes and load position decode
    always_comb begin
        nr      = clamp_dim(rows_reg);
        nk      = clamp_dim(inner_reg);
        nc      = clamp_dim(cols_reg);
        na_full = NA_W'(nr) * NA_W'(nk);
        nb_full = NA_W'(nk) * NA_W'(nc);
        na      = LC_W'(na_full);
        nb      = LC_W'(nb_full);
        total   = na + nb;
        pos_inc = load_cnt_reg + LC_W'(1);
        offs_b  = load_cnt_reg - na;
        in_a    = load_cnt_reg < na;
        in_b    = !in_a && (offs_b < nb);
        r_end   = DIM_W'(r_reg) == nr - DIM_W'(1);
        c_end   = DIM_W'(c_reg) == nc - DIM_W'(1);
        k_end   = DIM_W'(k_reg) == nk - DIM_W'(1);
        a_base  = MUL_W'(r_reg) * MUL_W'(nk) + MUL_W'(k_reg);
        b_base  = MUL_W'(k_reg) * MUL_W'(nc) + MUL_W'(c_reg);
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign waddr    = in_a ? AW'(load_cnt_reg) : AW'(offs_b);
    assign raddr_a  = AW'(a_base);
    assign raddr_b  = AW'(b_base);

    // Next-state and command logic
    always_comb begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        out_valid_next = (out_valid_reg && !m_tready) ? 1'b1 : 1'b0;

        cmd          = '0;
        cmd.out_row  = mme_pkg::ROW_W'(r_reg);
        cmd.out_col  = mme_pkg::ROW_W'(c_reg);
        cmd.out_last = r_end && c_end;
        cmd.first    = (k_reg == '0);
        cmd.last     = k_end;

        case (state_reg)
            ST_LOAD: begin
                if (s_xfer) begin
                    cmd.wr_a = in_a;
                    cmd.wr_b = in_b;
                    if (pos_inc >= total) begin
                        load_cnt_next = '0;
                        r_next        = '0;
                        c_next        = '0;
                        k_next        = '0;
                        state_next    = ST_ISSUE;
                    end else begin
                        load_cnt_next = pos_inc;
                    end
                end
            end
            ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (k_end) begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (status.sum_done && (!out_valid_reg || m_tready)) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    if (c_end) begin
                        c_next = '0;
                        if (r_end) begin
                            r_next     = '0;
                            state_next = ST_LOAD;
                        end else begin
                            r_next     = r_reg + IDX_W'(1);
                            state_next = ST_ISSUE;
                        end
                    end else begin
                        c_next     = c_reg + IDX_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State, counters, output valid and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            rows_reg      <= mme_pkg::DIM_RESET;
            inner_reg     <= mme_pkg::DIM_RESET;
            cols_reg      <= mme_pkg::DIM_RESET;
        end else begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    mme_pkg::REG_ROWS_A:    rows_reg  <= cfg_wdata;
                    mme_pkg::REG_INNER_DIM: inner_reg <= cfg_wdata;
                    mme_pkg::REG_COLS_B:    cols_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

[sv/mme_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_datapath
// Datapath: A/B element stores, registered multiplier, wide accumulator,
// Q-format shift with saturation, and the result payload register.
// ----------------------------------------------------------------------------
module mme_datapath #(
    parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF,
    localparam int AW = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mme_pkg::mme_cmd_t            cmd,
    output mme_pkg::mme_status_t         status,
    input  logic [AW-1:0]                waddr,
    input  logic [AW-1:0]                raddr_a,
    input  logic [AW-1:0]                raddr_b,
    input  logic [mme_pkg::ELEM_W-1:0]   elem,
    output logic [mme_pkg::ELEM_W-1:0]   out_value,
    output logic [mme_pkg::ROW_W-1:0]    out_row,
    output logic [mme_pkg::ROW_W-1:0]    out_col,
    output logic                         out_sat,
    output logic                         out_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int PROD_W = 2 * mme_pkg::ELEM_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

    logic [mme_pkg::ELEM_W-1:0] rd_a, rd_b;

    logic                     s1_valid_reg, s1_first_reg, s1_last_reg;
    logic                     s2_valid_reg, s2_first_reg, s2_last_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     done_reg, done_next;

    logic signed [ACC_W-1:0]    shifted;
    logic [ACC_W-mme_pkg::ELEM_W:0] hi_bits;
    logic                       fits;
    logic [mme_pkg::ELEM_W-1:0] fin_value;
    logic                       fin_sat;

    logic [mme_pkg::ELEM_W-1:0] out_value_reg;
    logic [mme_pkg::ROW_W-1:0]  out_row_reg, out_col_reg;
    logic                       out_sat_reg, out_last_reg;

    // Element stores
    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_a (
        .aclk  (aclk),
        .we    (cmd.wr_a),
        .waddr (waddr),
        .wdata (elem),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    mme_ram #(
        .WIDTH (mme_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_store_b (
        .aclk  (aclk),
        .we    (cmd.wr_b),
        .waddr (waddr),
        .wdata (elem),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    // Multiply and accumulate
    always_comb begin
        prod_next = $signed(rd_a) * $signed(rd_b);
        acc_next  = acc_reg;
        done_next = done_reg;
        if (s2_valid_reg) begin
            acc_next = s2_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (s2_valid_reg && s2_last_reg) begin
            done_next = 1'b1;
        end else if (cmd.load_out) begin
            done_next = 1'b0;
        end
    end

    // Drop fraction bits (floor), then clip to 32 bits
    always_comb begin
        shifted = acc_reg >>> FRAC_BITS;
        hi_bits = shifted[ACC_W-1:mme_pkg::ELEM_W-1];
        fits    = (&hi_bits) || !(|hi_bits);
        if (fits) begin
            fin_value = shifted[mme_pkg::ELEM_W-1:0];
            fin_sat   = 1'b0;
        end else begin
            fin_value = shifted[ACC_W-1] ? mme_pkg::Q_MIN : mme_pkg::Q_MAX;
            fin_sat   = 1'b1;
        end
    end

    // Pipeline tags and done flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            done_reg     <= done_next;
        end
    end

    // Product, accumulator and result payload
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.load_out) begin
            out_value_reg <= fin_value;
            out_sat_reg   <= fin_sat;
            out_row_reg   <= cmd.out_row;
            out_col_reg   <= cmd.out_col;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign status.sum_done = done_reg;
    assign out_value       = out_value_reg;
    assign out_row         = out_row_reg;
    assign out_col         = out_col_reg;
    assign out_sat         = out_sat_reg;
    assign out_last        = out_last_reg;

endmodule

[sv/matrix_multiply_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Q16.16 matrix multiply C = A * B with sizes set by three registers.
// ----------------------------------------------------------------------------
// Usage:
//   Write rows_a, inner_dim and cols_b through the cfg port (index 0..2).
//   Stream elements on s_*: all of A row-major, then all of B row-major,
//   one transfer per cycle while s_tready is high. The transfer that
//   completes B starts the product; s_tready stays low until the last
//   result has been placed in the output register.
//   Results leave on m_* in row-major order; m_tlast marks the final one.
//   One multiply-accumulate unit reads both stores through one read port
//   each. Each term passes the store read register, the product register
//   and the accumulator; a finished sum moves to the output register, and
//   the terms of the next result are issued only after that move.
//   A stalled receiver holds the output register; the datapath then waits
//   with the next finished sum and resumes once the result is taken.
//   Reset sets all three sizes to 8, clears the load position and drops
//   any result in flight. Store contents are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
    parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mme_pkg::DIM_CFG_W-1:0]     cfg_wdata,
    // element input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mme_pkg::IN_TDATA_W-1:0]    s_tdata,   // [31:0] element_value
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mme_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [31:0] product_value,
                                                         // [34:32] out_row,
                                                         // [37:35] out_col,
                                                         // [39:38] zero
    output logic                              m_tuser,   // [0] saturated
    output logic                              m_tlast    // last_element
);

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    mme_pkg::mme_cmd_t    cmd;
    mme_pkg::mme_status_t status;
    logic [AW-1:0]        waddr, raddr_a, raddr_b;

    logic [mme_pkg::ELEM_W-1:0] out_value;
    logic [mme_pkg::ROW_W-1:0]  out_row, out_col;

    // Sequencer
    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .status    (status),
        .waddr     (waddr),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b)
    );

    // Stores and arithmetic
    mme_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .waddr     (waddr),
        .raddr_a   (raddr_a),
        .raddr_b   (raddr_b),
        .elem      (s_tdata[mme_pkg::ELEM_W-1:0]),
        .out_value (out_value),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_sat   (m_tuser),
        .out_last  (m_tlast)
    );

    // Result packing
    assign m_tdata = {{mme_pkg::OUT_PAD_W{1'b0}}, out_col, out_row, out_value};

endmodule
